// ===== hdl/fwtt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwtt_pkg
// Shared types and codes of the four-way transposition table.
// ----------------------------------------------------------------------------
package fwtt_pkg;

  localparam int NUM_WAYS  = 4;
  localparam int WAY_BITS  = 2;
  localparam int IDX_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 15;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_INFINITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 8'd1;

  localparam logic [CFG_W-1:0] INFINITY_RST = 15'd30000;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 15'd1000;

  localparam logic REQ_PROBE = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  // One way of a bucket
  typedef struct packed {
    logic [31:0]        sig;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic               alpha_flag;
    logic               beta_flag;
    logic [63:0]        move;
  } way_t;

  // Laid out as {tuser, tdata}: bucket_index sits in the lowest tdata bits
  typedef struct packed {
    logic               req_type;
    logic [63:0]        new_best_move;
    logic signed [15:0] new_score;
    logic signed [15:0] beta;
    logic signed [15:0] alpha;
    logic [7:0]         search_depth;
    logic [7:0]         ply;
    logic [31:0]        signature;
    logic [IDX_W-1:0]   bucket_index;
  } req_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic match_en;
    logic finish_en;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

// ===== hdl/four_way_transposition_table.sv =====
`default_nettype none
// A result is registered after the match and update states; the update waits while the result register is full.
// A new item is accepted only once the last one is through: accept with bucket read, match, update.
// The bucket line is read and written back on the single memory port.
// After reset a clearing sweep zeroes all 2**BUCKET_BITS buckets, one bucket
// per cycle; no item is accepted meanwhile, config writes are.
// ----------------------------------------------------------------------------
// four_way_transposition_table
// Hashed search table of four-way buckets with probe and store requests.
// ----------------------------------------------------------------------------
module four_way_transposition_table import fwtt_pkg::*; #(
  parameter int BUCKET_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // req_type
  input  wire logic                 s_tuser,
  // bucket_index, signature, ply, search_depth, alpha, beta, new_score,
  // new_best_move
  input  wire logic [175:0]         s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // hit, score_valid, found
  output logic [2:0]                m_tuser,
  // score_out, best_move_out
  output logic [79:0]               m_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  fwtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fwtt_datapath #(
    .BUCKET_BITS (BUCKET_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

// ===== hdl/fwtt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwtt_ctrl
// Sequencer: clearing sweep, accept, bucket match, update and result load.
// ----------------------------------------------------------------------------
module fwtt_ctrl import fwtt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire logic     cfg_valid,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MATCH, ST_FINISH} state_t;

  state_t state;

  // Hold off items while a register write lands
  assign s_tready = (state == ST_IDLE) && !cfg_valid;

  always_comb begin
    cmd           = '0;
    cmd.clr_en    = (state == ST_CLEAR);
    cmd.accept    = s_tvalid && s_tready;
    cmd.match_en  = (state == ST_MATCH);
    cmd.finish_en = (state == ST_FINISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR:  if (sts.clr_last) state <= ST_IDLE;
        ST_IDLE:   if (cmd.accept) state <= ST_MATCH;
        ST_MATCH:  state <= ST_FINISH;
        ST_FINISH: if (sts.out_free) state <= ST_IDLE;
        default:   state <= ST_CLEAR;
      endcase
    end
  end

  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish_en |-> sts.out_free)
    else $error("update issued while result register is full");

  a_finish_after_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> ($past(state) == ST_MATCH || $past(state) == ST_FINISH))
    else $error("update stage entered without a match stage");

endmodule
`default_nettype wire

// ===== hdl/fwtt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwtt_datapath
// Bucket memory, request and config registers, match, score adjust, output.
// ----------------------------------------------------------------------------
module fwtt_datapath import fwtt_pkg::*; #(
  parameter int BUCKET_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctl_cmd_t             cmd,
  output ctl_sts_t                  sts,
  input  wire logic                 s_tuser,
  input  wire logic [175:0]         s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [2:0]                m_tuser,
  output logic [79:0]               m_tdata,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int NB = 1 << BUCKET_BITS;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767)       r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else                      r = v[15:0];
    return r;
  endfunction

  way_t [NUM_WAYS-1:0] mem [NB];
  way_t [NUM_WAYS-1:0] rd_line;
  way_t [NUM_WAYS-1:0] wr_line;
  way_t [NUM_WAYS-1:0] new_line;

  req_t req;
  req_t s_req;

  logic [BUCKET_BITS-1:0] clr_addr;
  logic [BUCKET_BITS-1:0] rd_addr;
  logic [BUCKET_BITS-1:0] req_addr;
  logic [BUCKET_BITS-1:0] wr_addr;
  logic [IDX_W+BUCKET_BITS-1:0] rd_ext;
  logic [IDX_W+BUCKET_BITS-1:0] req_ext;
  logic                   wr_en;

  logic [CFG_W-1:0]   infinity_score;
  logic [CFG_W-1:0]   exact_window;
  logic signed [17:0] thr_hi;
  logic signed [17:0] thr_lo;

  // Match stage
  logic [NUM_WAYS-1:0] match_vec;
  logic                match_any;
  logic [WAY_BITS-1:0] match_way;
  logic                found_q;
  logic [WAY_BITS-1:0] way_q;
  way_t                sel_q;

  // Store score prepared during the match stage
  logic signed [17:0] st_sc;
  logic signed [17:0] st_adj;
  logic signed [15:0] st_score_q;
  logic               st_aflag_q;
  logic               st_bflag_q;

  // Probe score adjustment
  logic signed [17:0] pr_sc;
  logic signed [17:0] pr_adj;
  logic signed [15:0] pr_score;
  logic               depth_ok;
  logic               pr_hit;
  logic               pr_valid;

  logic [WAY_BITS-1:0] last_way;
  logic [63:0]         old_best;
  way_t                head;

  logic               out_valid;
  logic               out_hit;
  logic               out_score_valid;
  logic signed [15:0] out_score;
  logic               out_found;
  logic [63:0]        out_best;

  assign s_req   = {s_tuser, s_tdata};
  assign rd_ext  = {{BUCKET_BITS{1'b0}}, s_req.bucket_index};
  assign rd_addr = rd_ext[BUCKET_BITS-1:0];
  assign req_ext = {{BUCKET_BITS{1'b0}}, req.bucket_index};
  assign req_addr = req_ext[BUCKET_BITS-1:0];

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      infinity_score <= INFINITY_RST;
      exact_window   <= WINDOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INFINITY: infinity_score <= cfg_data;
        CFG_WINDOW:   exact_window   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_hi <= $signed({3'b0, infinity_score}) - $signed({3'b0, exact_window});
    thr_lo <= $signed({3'b0, exact_window}) - $signed({3'b0, infinity_score});
  end

  // ---- clearing sweep ----
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_en) clr_addr <= clr_addr + 1'b1;
  end

  assign sts.clr_last = (clr_addr == {BUCKET_BITS{1'b1}});

  // ---- bucket memory ----
  assign wr_en   = cmd.clr_en || (cmd.finish_en && req.req_type == REQ_STORE);
  assign wr_addr = cmd.clr_en ? clr_addr : req_addr;
  assign wr_line = cmd.clr_en ? '0 : new_line;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_line;
    if (cmd.accept) rd_line <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) req <= s_req;
  end

  // ---- match stage ----
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      match_vec[w] = (rd_line[w].sig == req.signature);
    end
    match_any = |match_vec;
    match_way = WAY_BITS'(NUM_WAYS - 1);
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match_vec[w]) match_way = WAY_BITS'(w);
    end
  end

  always_comb begin
    st_sc = 18'(req.new_score);
    if (st_sc > thr_hi)      st_adj = st_sc + $signed({10'b0, req.ply});
    else if (st_sc < thr_lo) st_adj = st_sc - $signed({10'b0, req.ply});
    else                     st_adj = st_sc;
  end

  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      found_q    <= match_any;
      way_q      <= match_way;
      sel_q      <= rd_line[match_way];
      st_score_q <= sat16(st_adj);
      st_aflag_q <= (req.new_score <= req.alpha);
      st_bflag_q <= (req.new_score >= req.beta);
    end
  end

  // ---- update stage: store ----
  always_comb begin
    last_way = found_q ? way_q : WAY_BITS'(NUM_WAYS - 1);
    old_best = found_q ? sel_q.move : req.new_best_move;
    head.sig        = req.signature;
    head.depth      = req.search_depth;
    head.score      = st_score_q;
    head.alpha_flag = st_aflag_q;
    head.beta_flag  = st_bflag_q;
    head.move       = st_aflag_q ? old_best : req.new_best_move;
    new_line[0] = head;
    for (int k = 1; k < NUM_WAYS; k++) begin
      // shift the ways ahead of the replaced one down by one
      new_line[k] = (WAY_BITS'(k) <= last_way) ? rd_line[k-1] : rd_line[k];
    end
  end

  // ---- update stage: probe ----
  always_comb begin
    pr_sc = 18'(sel_q.score);
    if (pr_sc > thr_hi)      pr_adj = pr_sc - $signed({10'b0, req.ply});
    else if (pr_sc < thr_lo) pr_adj = pr_sc + $signed({10'b0, req.ply});
    else                     pr_adj = pr_sc;
    pr_score = sat16(pr_adj);
    depth_ok = found_q && (sel_q.depth >= req.search_depth);
    pr_hit   = 1'b0;
    pr_valid = 1'b0;
    if (depth_ok) begin
      if (sel_q.beta_flag) begin
        if (pr_score >= req.beta) begin
          pr_hit   = 1'b1;
          pr_valid = 1'b1;
        end else if (pr_score > req.alpha) begin
          pr_valid = 1'b1;
        end
      end else if (sel_q.alpha_flag) begin
        if (pr_score <= req.alpha) begin
          pr_hit   = 1'b1;
          pr_valid = 1'b1;
        end
      end else begin
        pr_hit   = 1'b1;
        pr_valid = 1'b1;
      end
    end
  end

  // ---- result register ----
  assign sts.out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish_en) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_en) begin
      if (req.req_type == REQ_STORE) begin
        out_hit         <= 1'b0;
        out_score_valid <= 1'b0;
        out_score       <= '0;
        out_found       <= 1'b0;
        out_best        <= '0;
      end else begin
        out_hit         <= pr_hit;
        out_score_valid <= pr_valid;
        out_score       <= pr_valid ? pr_score : 16'sd0;
        out_found       <= found_q;
        out_best        <= found_q ? sel_q.move : 64'd0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = {out_found, out_score_valid, out_hit};
  assign m_tdata  = {out_best, out_score};

  a_store_result_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish_en && req.req_type == REQ_STORE) |=>
      (!out_hit && !out_score_valid && !out_found && out_score == 16'sd0
       && out_best == 64'd0))
    else $error("store produced a nonzero result");

  a_flag_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!out_hit || out_score_valid) && (!out_score_valid || out_found)))
    else $error("hit or score without a matching way");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-way transposition table.
// Drives probe and store items on the input stream, predicts every result
// from a behavioral copy of the buckets and configuration, and compares each
// result field by field, with phases in which both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import fwtt_pkg::*;

  localparam int TABLE_BUCKET_BITS = 16;
  localparam int BUCKET_MASK = (1 << TABLE_BUCKET_BITS) - 1;
  // Index past the register list; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd2;

  typedef struct packed {
    logic               hit;
    logic               score_valid;
    logic signed [15:0] score_out;
    logic               found;
    logic [63:0]        best_move_out;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic s_tuser = 1'b0;
  logic [175:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [2:0] m_tuser;
  logic [79:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Behavioral copy of the table, keyed by bucket * 4 + way
  way_t table_ways[int];
  int cfg_infinity = int'(INFINITY_RST);
  int cfg_window = int'(WINDOW_RST);
  lookup_result_t expected_results[$];

  logic [15:0] hot_bucket[8];
  logic [31:0] hot_sig[6];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_left = 0;
  int fail_count = 0;

  four_way_transposition_table #(
    .BUCKET_BITS(TABLE_BUCKET_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser(m_tuser),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int clamp_score(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // +1 winning distance score, -1 losing distance score, 0 otherwise
  function automatic int distance_class(int s);
    if (s > cfg_infinity - cfg_window) return 1;
    if (s < cfg_window - cfg_infinity) return -1;
    return 0;
  endfunction

  function automatic lookup_result_t predict_table_access(req_t r);
    int base, match, last, s, c, a, b;
    way_t cur[4];
    way_t ent;
    lookup_result_t res;
    base = (int'(r.bucket_index) & BUCKET_MASK) * 4;
    for (int w = 0; w < 4; w++)
      cur[w] = table_ways.exists(base + w) ? table_ways[base + w] : '0;
    match = -1;
    for (int w = 3; w >= 0; w--)
      if (cur[w].sig == r.signature) match = w;
    res = '0;
    a = $signed(r.alpha);
    b = $signed(r.beta);
    if (r.req_type == REQ_STORE) begin
      last = (match < 0) ? 3 : match;
      for (int k = last; k > 0; k--) table_ways[base + k] = cur[k - 1];
      s = $signed(r.new_score);
      ent.sig = r.signature;
      ent.depth = r.search_depth;
      ent.alpha_flag = (s <= a);
      ent.beta_flag = (s >= b);
      // an alpha-bound store keeps the old best move of the matching way
      if (ent.alpha_flag && match >= 0) ent.move = cur[match].move;
      else ent.move = r.new_best_move;
      c = distance_class(s);
      if (c > 0) s = s + int'(r.ply);
      else if (c < 0) s = s - int'(r.ply);
      ent.score = 16'(clamp_score(s));
      table_ways[base] = ent;
    end else if (match >= 0) begin
      ent = cur[match];
      res.found = 1'b1;
      res.best_move_out = ent.move;
      if (ent.depth >= r.search_depth) begin
        s = $signed(ent.score);
        c = distance_class(s);
        if (c > 0) s = s - int'(r.ply);
        else if (c < 0) s = s + int'(r.ply);
        s = clamp_score(s);
        if (ent.beta_flag) begin
          if (s >= b) begin
            res.hit = 1'b1;
            res.score_valid = 1'b1;
          end else if (s > a) begin
            res.score_valid = 1'b1;
          end
        end else if (ent.alpha_flag) begin
          if (s <= a) begin
            res.hit = 1'b1;
            res.score_valid = 1'b1;
          end
        end else begin
          res.hit = 1'b1;
          res.score_valid = 1'b1;
        end
        if (res.score_valid) res.score_out = 16'(s);
      end
    end
    return res;
  endfunction

  function automatic req_t make_request(logic kind, logic [15:0] bucket, logic [31:0] sig,
                                        int ply, int depth, int alpha, int beta, int score,
                                        logic [63:0] move);
    req_t r;
    r.req_type = kind;
    r.bucket_index = bucket;
    r.signature = sig;
    r.ply = 8'(ply);
    r.search_depth = 8'(depth);
    r.alpha = 16'(alpha);
    r.beta = 16'(beta);
    r.new_score = 16'(score);
    r.new_best_move = move;
    return r;
  endfunction

  function automatic int pick_score();
    case ($urandom_range(4))
      0: return int'($urandom_range(65535)) - 32768;
      1: return clamp_score(cfg_infinity - int'($urandom_range(1500)));
      2: return clamp_score(int'($urandom_range(1500)) - cfg_infinity);
      3: return $urandom_range(1) ? 32767 : -32768;
      default: return int'($urandom_range(400)) - 200;
    endcase
  endfunction

  // Hot buckets and signatures make stores and later probes meet
  function automatic req_t random_request(int store_pct);
    req_t r;
    int sc;
    r.req_type = ($urandom_range(99) < store_pct) ? REQ_STORE : REQ_PROBE;
    r.bucket_index = ($urandom_range(3) != 0) ? hot_bucket[$urandom_range(7)] : 16'($urandom);
    if ($urandom_range(4) != 0) begin
      r.signature = hot_sig[$urandom_range(5)];
    end else begin
      do r.signature = $urandom; while (r.signature == 32'd0);
    end
    r.ply = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
    if (r.req_type == REQ_PROBE && $urandom_range(1)) r.search_depth = 8'($urandom_range(20));
    else r.search_depth = 8'($urandom);
    sc = pick_score();
    r.new_score = 16'(sc);
    if ($urandom_range(1)) begin
      r.alpha = 16'(clamp_score(sc - int'($urandom_range(300))));
      r.beta = 16'(clamp_score(sc + int'($urandom_range(300))));
    end else begin
      r.alpha = 16'($urandom);
      r.beta = 16'($urandom);
    end
    r.new_best_move = {$urandom, $urandom};
    return r;
  endfunction

  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.req_type;
    s_tdata <= {r.new_best_move, r.new_score, r.beta, r.alpha, r.search_depth, r.ply,
                r.signature, r.bucket_index};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_table_access(r));
  endtask

  task automatic send_random(int count, int store_pct);
    for (int i = 0; i < count; i++) send_request(random_request(store_pct));
  endtask

  // Hold the input until every expected result is out, then let the pipe settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_INFINITY) cfg_infinity = int'(value);
    else if (idx == CFG_WINDOW) cfg_window = int'(value);
  endtask

  task automatic test_directed();
    // exact entry at the field extremes
    send_request(make_request(REQ_STORE, 16'd0, 32'hFFFF_FFFF, 0, 255, -1, 1, 0, '1));
    send_request(make_request(REQ_PROBE, 16'd0, 32'hFFFF_FFFF, 0, 255, -32768, 32767, 0, '0));
    send_request(make_request(REQ_PROBE, 16'd0, 32'hFFFF_FFFF, 255, 0, 0, 0, 0, '0));
    // winning score saturates on store; lower bound only on probe
    send_request(make_request(REQ_STORE, 16'hFFFF, 32'd1, 255, 10, -32768, 32767, 32767,
                              64'hA5A5_0000_FFFF_0001));
    send_request(make_request(REQ_PROBE, 16'hFFFF, 32'd1, 255, 10, -32768, 32767, 0, '0));
    send_request(make_request(REQ_PROBE, 16'hFFFF, 32'd1, 0, 10, -32768, 0, 0, '0));
    // losing score saturates low, upper bound entry
    send_request(make_request(REQ_STORE, 16'hFFFF, 32'd2, 255, 20, -32768, 32767, -32768,
                              64'h8000_0000_0000_0001));
    send_request(make_request(REQ_PROBE, 16'hFFFF, 32'd2, 200, 20, 0, 100, 0, '0));
    send_request(make_request(REQ_PROBE, 16'hFFFF, 32'd2, 0, 21, 0, 100, 0, '0));
    // both bounds set; probe tests the lower bound first
    send_request(make_request(REQ_STORE, 16'd1, 32'd3, 0, 5, 100, -100, 0,
                              64'h0123_4567_89AB_CDEF));
    send_request(make_request(REQ_PROBE, 16'd1, 32'd3, 0, 5, -10, -5, 0, '0));
    send_request(make_request(REQ_PROBE, 16'd1, 32'd3, 0, 5, 10, 20, 0, '0));
    // upper bound store over a matching way keeps its best move
    send_request(make_request(REQ_STORE, 16'd1, 32'd3, 0, 7, 50, 60, 40, '1));
    send_request(make_request(REQ_PROBE, 16'd1, 32'd3, 0, 0, 45, 60, 0, '0));
    // five signatures into one bucket evict the oldest
    for (int i = 0; i < 5; i++)
      send_request(make_request(REQ_STORE, 16'd2, 32'd11 + i, 3, 40 + i, -500, 500,
                                i * 10, {32'($urandom), 32'(i)}));
    send_request(make_request(REQ_PROBE, 16'd2, 32'd11, 0, 0, -500, 500, 0, '0));
    send_request(make_request(REQ_PROBE, 16'd2, 32'd12, 0, 0, -500, 500, 0, '0));
    send_request(make_request(REQ_PROBE, 16'd3, 32'h1234_5678, 0, 0, -500, 500, 0, '0));
    // refresh a middle way; the way behind it must stay
    send_request(make_request(REQ_STORE, 16'd2, 32'd13, 0, 90, -500, 500, 29001, '0));
    send_request(make_request(REQ_PROBE, 16'd2, 32'd12, 0, 0, -500, 500, 0, '0));
    send_request(make_request(REQ_PROBE, 16'd2, 32'd13, 100, 90, -500, 30000, 0, '0));
  endtask

  task automatic test_config_settings();
    write_register(CFG_INFINITY, 15'd0);
    write_register(CFG_WINDOW, 15'd0);
    send_random(25, 45);
    write_register(CFG_INFINITY, 15'd32767);
    write_register(CFG_WINDOW, 15'd32767);
    send_random(25, 45);
    write_register(CFG_WINDOW, 15'd0);
    send_random(25, 45);
    write_register(CFG_INFINITY, 15'd0);
    write_register(CFG_WINDOW, 15'd32767);
    send_random(25, 45);
    write_register(CFG_INFINITY, 15'd100);
    write_register(CFG_WINDOW, 15'd50);
    send_random(25, 45);
    write_register(CFG_INFINITY, INFINITY_RST);
    write_register(CFG_WINDOW, WINDOW_RST);
    write_register(CFG_UNMAPPED, 15'h7FFF);
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(60, 40);
    send_idle_pct = 69;
    send_random(60, 40);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    send_random(60, 40);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    send_random(60, 40);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    send_random(40, 40);
    wait_idle();
    send_random(20, 40);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tuser %0h tdata %0h",
                 $time, m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("hit", want.hit, m_tuser[0]);
        check_field("score_valid", want.score_valid, m_tuser[1]);
        check_field("found", want.found, m_tuser[2]);
        check_field("score_out", 64'(want.score_out[15:0]), 64'(m_tdata[15:0]));
        check_field("best_move_out", want.best_move_out, m_tdata[79:16]);
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    hot_bucket[0] = 16'h0000;
    hot_bucket[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) hot_bucket[i] = 16'($urandom);
    hot_sig[0] = 32'hFFFF_FFFF;
    hot_sig[1] = 32'd1;
    for (int i = 2; i < 6; i++) begin
      do hot_sig[i] = $urandom; while (hot_sig[i] == 32'd0);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_settings();
    test_idle_phases();
    test_backpressure();
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
